### rtl/assert_macros.svh
// Assertion macros shared by the report builder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Expression holds at every clock edge outside reset
`define BMRB_ASSERT_HOLD(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent
`define BMRB_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent
`define BMRB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BMRB_ASSERT_HOLD(lbl, clk, rst, expr)
`define BMRB_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define BMRB_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/bmrb_pkg.sv
// Types, codes and helpers shared by the boot mouse report builder.
package bmrb_pkg;

  // Event opcodes
  localparam logic [2:0] OP_REL_X  = 3'd0;
  localparam logic [2:0] OP_REL_Y  = 3'd1;
  localparam logic [2:0] OP_ABS_X  = 3'd2;
  localparam logic [2:0] OP_ABS_Y  = 3'd3;
  localparam logic [2:0] OP_BUTTON = 3'd4;
  localparam logic [2:0] OP_SYNC   = 3'd5;

  // Register indexes on the APB port
  localparam logic [2:0] REG_ABS_MODE = 3'd0;
  localparam logic [2:0] REG_SCALE_X  = 3'd1;
  localparam logic [2:0] REG_SCALE_Y  = 3'd2;
  localparam logic [2:0] REG_START_X  = 3'd3;
  localparam logic [2:0] REG_START_Y  = 3'd4;

  localparam int NUM_BUTTONS = 5;
  localparam int SCALE_BITS  = 24;
  localparam int CARRY_BITS  = 25;
  localparam int STEP_BITS   = 4;

  // Datapath actions of a microcode step
  localparam logic [3:0] ACT_NOP    = 4'd0;
  localparam logic [3:0] ACT_EVENT  = 4'd1;
  localparam logic [3:0] ACT_LOAD_X = 4'd2;
  localparam logic [3:0] ACT_LOAD_Y = 4'd3;
  localparam logic [3:0] ACT_STEP   = 4'd4;
  localparam logic [3:0] ACT_STORE_X = 4'd5;
  localparam logic [3:0] ACT_STORE_Y = 4'd6;
  localparam logic [3:0] ACT_LATCH  = 4'd7;
  localparam logic [3:0] ACT_EMIT   = 4'd8;

  // Jump conditions of a microcode step
  localparam logic [2:0] COND_NEVER     = 3'd0;
  localparam logic [2:0] COND_NO_SYNC   = 3'd1;
  localparam logic [2:0] COND_REL       = 3'd2;
  localparam logic [2:0] COND_NOT_FIRST = 3'd3;
  localparam logic [2:0] COND_DIV_MORE  = 3'd4;
  localparam logic [2:0] COND_OUT_BUSY  = 3'd5;
  localparam logic [2:0] COND_ALWAYS    = 3'd6;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [2:0]         button_index;
  } ev_item_t;

  typedef struct packed {
    logic [2:0]        buttons;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
  } rpt_item_t;

  typedef struct packed {
    logic                 take;
    logic [3:0]           act;
    logic [2:0]           cond;
    logic [STEP_BITS-1:0] target;
  } ctl_word_t;

  // Status bits the sequencer branches on
  typedef struct packed {
    logic sync_hit;
    logic rel_mode;
    logic not_first;
    logic div_more;
    logic out_busy;
  } seq_stat_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  typedef struct packed {
    logic                         more;
    logic signed [7:0]            quot;
    logic signed [CARRY_BITS-1:0] rem;
  } div_res_t;

  // Clamp a motion value to the +-127 report range
  function automatic logic signed [7:0] clamp_report(input logic signed [31:0] v);
    logic signed [7:0] r;
    if (v > 32'sd127) begin
      r = 8'sd127;
    end else if (v < -32'sd127) begin
      r = -8'sd127;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

### rtl/bmrb_div.sv
// Bit-serial signed divider: truncating quotient (clamped to +-127) and remainder.
`include "assert_macros.svh"

module bmrb_div
  import bmrb_pkg::*;
#(
  parameter int RAW_BITS = 34
) (
  input  logic                       clk,
  input  logic                       rst,
  input  div_ctl_t                   ctl,
  input  logic signed [RAW_BITS-1:0] raw,
  input  logic [SCALE_BITS-1:0]      scale,
  output div_res_t                   res
);

  localparam int MAG_BITS = RAW_BITS - 1;
  localparam int CNT_BITS = $clog2(MAG_BITS + 1);

  logic                  neg;
  logic [MAG_BITS-1:0]   mag;
  logic [SCALE_BITS-1:0] rem;
  logic [SCALE_BITS-1:0] div;
  logic [CNT_BITS-1:0]   cnt;

  logic signed [RAW_BITS-1:0] raw_abs;
  logic [SCALE_BITS:0]        trial;
  logic [SCALE_BITS:0]        diff;
  logic                       ge;
  logic [6:0]                 mag7;
  logic [SCALE_BITS:0]        rem_ext;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign raw_abs = raw[RAW_BITS-1] ? -raw : raw;
  assign trial   = {rem, mag[MAG_BITS-1]};
  assign diff    = trial - {1'b0, div};
  assign ge      = (trial >= {1'b0, div});

  always_ff @(posedge clk) begin
    if (rst) begin
      neg <= 1'b0;
      mag <= '0;
      rem <= '0;
      div <= SCALE_BITS'(1);
      cnt <= '0;
    end else if (ctl.load) begin
      neg <= raw[RAW_BITS-1];
      mag <= raw_abs[MAG_BITS-1:0];
      rem <= '0;
      div <= (scale == '0) ? SCALE_BITS'(1) : scale;
      cnt <= CNT_BITS'(MAG_BITS);
    end else if (ctl.step) begin
      mag <= {mag[MAG_BITS-2:0], ge};
      rem <= ge ? diff[SCALE_BITS-1:0] : trial[SCALE_BITS-1:0];
      cnt <= cnt - CNT_BITS'(1);
    end
  end

  // Signed results: quotient and remainder take the dividend's sign
  assign mag7    = (mag > MAG_BITS'(127)) ? 7'd127 : mag[6:0];
  assign rem_ext = {1'b0, rem};

  assign res.more = (cnt != CNT_BITS'(1));
  assign res.quot = neg ? -$signed({1'b0, mag7}) : $signed({1'b0, mag7});
  assign res.rem  = neg ? -$signed(rem_ext) : $signed(rem_ext);

  `BMRB_ASSERT_HOLD(a_rem_below_div, clk, rst, rem < div)
  `BMRB_ASSERT_HOLD(a_div_nonzero, clk, rst, div != '0)
  `BMRB_ASSERT_NEXT(a_load_resets_rem, clk, rst, ctl.load, rem == '0)

endmodule

### rtl/bmrb_seq.sv
// Microcode sequencer: step counter, control store and branch logic.
module bmrb_seq
  import bmrb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  seq_stat_t stat,
  output ctl_word_t ctl
);

  localparam logic [STEP_BITS-1:0] S_IDLE    = 4'd0;
  localparam logic [STEP_BITS-1:0] S_MODE    = 4'd1;
  localparam logic [STEP_BITS-1:0] S_FIRST   = 4'd2;
  localparam logic [STEP_BITS-1:0] S_LOAD_X  = 4'd3;
  localparam logic [STEP_BITS-1:0] S_DIV_X   = 4'd4;
  localparam logic [STEP_BITS-1:0] S_STORE_X = 4'd5;
  localparam logic [STEP_BITS-1:0] S_LOAD_Y  = 4'd6;
  localparam logic [STEP_BITS-1:0] S_DIV_Y   = 4'd7;
  localparam logic [STEP_BITS-1:0] S_STORE_Y = 4'd8;
  localparam logic [STEP_BITS-1:0] S_LATCH   = 4'd9;
  localparam logic [STEP_BITS-1:0] S_EMIT    = 4'd10;
  localparam logic [STEP_BITS-1:0] S_RETURN  = 4'd11;

  logic [STEP_BITS-1:0] pc;
  logic [STEP_BITS-1:0] pc_next;
  logic                 jump;

  // Control store: take, action, condition, target
  function automatic ctl_word_t rom_word(input logic [STEP_BITS-1:0] a);
    ctl_word_t w;
    unique case (a)
      S_IDLE:    w = '{1'b1, ACT_EVENT,   COND_NO_SYNC,   S_IDLE};
      S_MODE:    w = '{1'b0, ACT_NOP,     COND_REL,       S_EMIT};
      S_FIRST:   w = '{1'b0, ACT_NOP,     COND_NOT_FIRST, S_LATCH};
      S_LOAD_X:  w = '{1'b0, ACT_LOAD_X,  COND_NEVER,     S_IDLE};
      S_DIV_X:   w = '{1'b0, ACT_STEP,    COND_DIV_MORE,  S_DIV_X};
      S_STORE_X: w = '{1'b0, ACT_STORE_X, COND_NEVER,     S_IDLE};
      S_LOAD_Y:  w = '{1'b0, ACT_LOAD_Y,  COND_NEVER,     S_IDLE};
      S_DIV_Y:   w = '{1'b0, ACT_STEP,    COND_DIV_MORE,  S_DIV_Y};
      S_STORE_Y: w = '{1'b0, ACT_STORE_Y, COND_NEVER,     S_IDLE};
      S_LATCH:   w = '{1'b0, ACT_LATCH,   COND_NEVER,     S_IDLE};
      S_EMIT:    w = '{1'b0, ACT_EMIT,    COND_OUT_BUSY,  S_EMIT};
      S_RETURN:  w = '{1'b0, ACT_NOP,     COND_ALWAYS,    S_IDLE};
      default:   w = '{1'b0, ACT_NOP,     COND_ALWAYS,    S_IDLE};
    endcase
    return w;
  endfunction

  assign ctl = rom_word(pc);

  // Branch condition select
  always_comb begin
    unique case (ctl.cond)
      COND_NO_SYNC:   jump = !stat.sync_hit;
      COND_REL:       jump = stat.rel_mode;
      COND_NOT_FIRST: jump = stat.not_first;
      COND_DIV_MORE:  jump = stat.div_more;
      COND_OUT_BUSY:  jump = stat.out_busy;
      COND_ALWAYS:    jump = 1'b1;
      default:        jump = 1'b0;
    endcase
  end

  assign pc_next = jump ? ctl.target : pc + STEP_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### rtl/boot_mouse_report_builder_core.sv
// Top level of the boot mouse report builder.
//
// Pointer events enter on the ev channel (ev_valid/ev_stall, payload ev) and
// boot reports leave on the rpt channel (rpt_valid/rpt_stall, payload rpt).
// A beat moves when valid is high and stall is low. Registers sit on an APB
// port at byte addresses 0,4,8,12,16: absolute mode, X and Y scale, X and Y
// start position. Write them only while the block is idle.
// Motion, absolute and button events are absorbed in the idle step, and so
// is a sync with nothing pending, which gives no report. A reporting sync
// in relative mode goes from the mode check to the emit step; the first one
// in absolute mode latches the position before it emits. Later absolute
// syncs run both axes through one shared bit-serial divider of M steps
// each, one quotient bit per cycle (M = COORD_BITS+1 when COORD_BITS >= 24,
// else 25), store quotient and remainder, latch the position and emit.
// After the emit step the sequencer returns to idle and takes the next event.
// A finished report waits in the output register while the next events are
// accepted; if a new report is ready while rpt is stalled, the sequencer
// holds and ev stalls until the old beat is taken.
// Synchronous reset returns every register but the rpt payload to its default and state to zero.
`include "assert_macros.svh"

module boot_mouse_report_builder_core
  import bmrb_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        ev_valid,
  output logic        ev_stall,
  input  ev_item_t    ev,
  output logic        rpt_valid,
  input  logic        rpt_stall,
  output rpt_item_t   rpt,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RAW_BITS = ((COORD_BITS + 1 > CARRY_BITS) ? COORD_BITS + 1 : CARRY_BITS) + 1;

  // Configuration registers
  logic                         absolute_mode;
  logic [SCALE_BITS-1:0]        scale_x;
  logic [SCALE_BITS-1:0]        scale_y;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;

  // Event state
  logic [NUM_BUTTONS-1:0]       button_bits;
  logic signed [31:0]           accum_x;
  logic signed [31:0]           accum_y;
  logic                         pending;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic                         first_sync_done;
  logic signed [CARRY_BITS-1:0] carry_x;
  logic signed [CARRY_BITS-1:0] carry_y;

  ctl_word_t ctl;
  seq_stat_t stat;
  div_ctl_t  dctl;
  div_res_t  dres;

  logic                       ev_acc;
  logic                       cfg_wr;
  logic                       rpt_busy;
  logic signed [RAW_BITS-1:0] raw_x;
  logic signed [RAW_BITS-1:0] raw_y;
  logic signed [RAW_BITS-1:0] raw_sel;
  logic [SCALE_BITS-1:0]      scale_sel;
  logic signed [32:0]         sum_x;
  logic signed [32:0]         sum_y;
  logic signed [31:0]         sat_x;
  logic signed [31:0]         sat_y;

  assign ev_stall = !ctl.take;
  assign ev_acc   = ev_valid && !ev_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign rpt_busy = rpt_valid && rpt_stall;

  // Sequencer
  assign stat.sync_hit  = ev_acc && (ev.op == OP_SYNC) && pending;
  assign stat.rel_mode  = !absolute_mode;
  assign stat.not_first = !first_sync_done;
  assign stat.div_more  = dres.more;
  assign stat.out_busy  = rpt_busy;

  bmrb_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  // Divider operand: position delta plus carry for the selected axis
  assign raw_x = RAW_BITS'(pos_x) - RAW_BITS'(prev_x) + RAW_BITS'(carry_x);
  assign raw_y = RAW_BITS'(pos_y) - RAW_BITS'(prev_y) + RAW_BITS'(carry_y);
  assign raw_sel   = (ctl.act == ACT_LOAD_Y) ? raw_y : raw_x;
  assign scale_sel = (ctl.act == ACT_LOAD_Y) ? scale_y : scale_x;

  assign dctl.load = (ctl.act == ACT_LOAD_X) || (ctl.act == ACT_LOAD_Y);
  assign dctl.step = (ctl.act == ACT_STEP);

  bmrb_div #(
    .RAW_BITS (RAW_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .ctl   (dctl),
    .raw   (raw_sel),
    .scale (scale_sel),
    .res   (dres)
  );

  // Saturating relative motion sums
  assign sum_x = 33'(accum_x) + 33'(ev.value);
  assign sum_y = 33'(accum_y) + 33'(ev.value);
  assign sat_x = (sum_x[32] != sum_x[31]) ? {sum_x[32], {31{!sum_x[32]}}} : sum_x[31:0];
  assign sat_y = (sum_y[32] != sum_y[31]) ? {sum_y[32], {31{!sum_y[32]}}} : sum_y[31:0];

  // Register reads
  always_comb begin
    unique case (paddr[4:2])
      REG_ABS_MODE: prdata = {31'd0, absolute_mode};
      REG_SCALE_X:  prdata = {8'd0, scale_x};
      REG_SCALE_Y:  prdata = {8'd0, scale_y};
      REG_START_X:  prdata = 32'(start_x);
      REG_START_Y:  prdata = 32'(start_y);
      default:      prdata = '0;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      absolute_mode <= 1'b0;
      scale_x       <= SCALE_BITS'(1);
      scale_y       <= SCALE_BITS'(1);
      start_x       <= '0;
      start_y       <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_ABS_MODE: absolute_mode <= pwdata[0];
        REG_SCALE_X:  scale_x <= pwdata[SCALE_BITS-1:0];
        REG_SCALE_Y:  scale_y <= pwdata[SCALE_BITS-1:0];
        REG_START_X:  start_x <= pwdata[COORD_BITS-1:0];
        REG_START_Y:  start_y <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Event state and datapath actions
  always_ff @(posedge clk) begin
    if (rst) begin
      button_bits     <= '0;
      accum_x         <= '0;
      accum_y         <= '0;
      pending         <= 1'b0;
      pos_x           <= '0;
      pos_y           <= '0;
      prev_x          <= '0;
      prev_y          <= '0;
      first_sync_done <= 1'b0;
      carry_x         <= '0;
      carry_y         <= '0;
    end else begin
      // a start write reloads the position pair of its axis
      if (cfg_wr && (paddr[4:2] == REG_START_X)) begin
        pos_x  <= pwdata[COORD_BITS-1:0];
        prev_x <= pwdata[COORD_BITS-1:0];
      end
      if (cfg_wr && (paddr[4:2] == REG_START_Y)) begin
        pos_y  <= pwdata[COORD_BITS-1:0];
        prev_y <= pwdata[COORD_BITS-1:0];
      end
      case (ctl.act)
        ACT_EVENT: begin
          if (ev_acc) begin
            case (ev.op)
              OP_REL_X: begin
                accum_x <= sat_x;
                pending <= 1'b1;
              end
              OP_REL_Y: begin
                accum_y <= sat_y;
                pending <= 1'b1;
              end
              OP_ABS_X: begin
                if (absolute_mode) begin
                  pos_x   <= ev.value[COORD_BITS-1:0];
                  pending <= 1'b1;
                end
              end
              OP_ABS_Y: begin
                if (absolute_mode) begin
                  pos_y   <= ev.value[COORD_BITS-1:0];
                  pending <= 1'b1;
                end
              end
              OP_BUTTON: begin
                if (ev.button_index < 3'(NUM_BUTTONS)) begin
                  button_bits[ev.button_index] <= (ev.value != '0);
                  pending <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ACT_STORE_X: begin
          accum_x <= 32'(dres.quot);
          carry_x <= dres.rem;
        end
        ACT_STORE_Y: begin
          accum_y <= 32'(dres.quot);
          carry_y <= dres.rem;
        end
        ACT_LATCH: begin
          first_sync_done <= first_sync_done || absolute_mode;
          if (absolute_mode) begin
            prev_x <= pos_x;
            prev_y <= pos_y;
          end
        end
        ACT_EMIT: begin
          if (!rpt_busy) begin
            accum_x <= '0;
            accum_y <= '0;
            pending <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if ((ctl.act == ACT_EMIT) && !rpt_busy) begin
      rpt_valid <= 1'b1;
    end else if (rpt_valid && !rpt_stall) begin
      rpt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctl.act == ACT_EMIT) && !rpt_busy) begin
      rpt.buttons <= button_bits[2:0];
      rpt.delta_x <= clamp_report(accum_x);
      rpt.delta_y <= clamp_report(accum_y);
    end
  end

  `BMRB_ASSERT_IMPL(a_report_had_pending, clk, rst, $rose(rpt_valid), $past(pending))
  `BMRB_ASSERT_IMPL(a_report_clears_pending, clk, rst, $rose(rpt_valid), !pending)
  `BMRB_ASSERT_NEXT(a_rel_keeps_first, clk, rst, !absolute_mode, $stable(first_sync_done))

endmodule

### tb/boot_mouse_report_builder_core_test.sv
// Self-checking testbench for the boot mouse report builder core.
module boot_mouse_report_builder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bmrb_pkg::*;

  // Opcodes the block ignores, and button slots
  localparam logic [2:0] OP_SPARE_6  = 3'd6;
  localparam logic [2:0] OP_SPARE_7  = 3'd7;
  localparam logic [2:0] SLOT_LEFT   = 3'd0;
  localparam logic [2:0] SLOT_RIGHT  = 3'd1;
  localparam logic [2:0] SLOT_MIDDLE = 3'd2;
  localparam logic [2:0] SLOT_SIDE   = 3'd3;
  localparam logic [2:0] SLOT_EXTRA  = 3'd4;

  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    ev_item_t  item;
    bit        has_want;
    rpt_item_t want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        ev_valid;
  logic        ev_stall;
  ev_item_t    ev;
  logic        rpt_valid;
  logic        rpt_stall;
  rpt_item_t   rpt;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  boot_mouse_report_builder_core dut (
    .clk      (clk),
    .rst      (rst),
    .ev_valid (ev_valid),
    .ev_stall (ev_stall),
    .ev       (ev),
    .rpt_valid(rpt_valid),
    .rpt_stall(rpt_stall),
    .rpt      (rpt),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow registers
  bit          abs_on;
  logic [23:0] div_x;
  logic [23:0] div_y;

  // Shadow pointer state
  logic [4:0]  btn_state;
  longint      acc_x;
  longint      acc_y;
  bit          dirty;
  longint      cur_x;
  longint      cur_y;
  longint      last_x;
  longint      last_y;
  bit          latched;
  longint      rem_x;
  longint      rem_y;

  rpt_item_t   pending_reports[$];
  dir_row_t    dir_rows[$];
  int          fail_cnt;
  bit          hold_req;
  bit          no_idle;
  int          quiet_items;

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic [7:0] clip8(input longint v);
    if (v > 127) begin
      v = 127;
    end else if (v < -127) begin
      v = -127;
    end
    return v[7:0];
  endfunction

  // Predict the effect of one accepted event; fired flags a report
  function automatic void apply_pointer_event(input ev_item_t e, output bit fired,
                                              output rpt_item_t r);
    longint val;
    longint dv;
    longint raw;
    val = longint'(e.value);
    fired = 1'b0;
    r = '0;
    case (e.op)
      OP_REL_X: begin
        acc_x = sat32(acc_x + val);
        dirty = 1'b1;
      end
      OP_REL_Y: begin
        acc_y = sat32(acc_y + val);
        dirty = 1'b1;
      end
      OP_ABS_X: begin
        if (abs_on) begin
          cur_x = val;
          dirty = 1'b1;
        end
      end
      OP_ABS_Y: begin
        if (abs_on) begin
          cur_y = val;
          dirty = 1'b1;
        end
      end
      OP_BUTTON: begin
        if (e.button_index < NUM_BUTTONS) begin
          btn_state[e.button_index] = (e.value != 0);
          dirty = 1'b1;
        end
      end
      OP_SYNC: begin
        if (dirty) begin
          if (abs_on) begin
            // first reporting sync only latches the position
            if (!latched) begin
              latched = 1'b1;
            end else begin
              dv = (div_x == 0) ? 64'sd1 : longint'(div_x);
              raw = cur_x - last_x + rem_x;
              acc_x = raw / dv;
              rem_x = raw % dv;
              dv = (div_y == 0) ? 64'sd1 : longint'(div_y);
              raw = cur_y - last_y + rem_y;
              acc_y = raw / dv;
              rem_y = raw % dv;
            end
            last_x = cur_x;
            last_y = cur_y;
          end
          fired = 1'b1;
          r.buttons = btn_state[2:0];
          r.delta_x = clip8(acc_x);
          r.delta_y = clip8(acc_y);
          acc_x = 0;
          acc_y = 0;
          dirty = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic dir_row_t mk_row(input logic [2:0] op, input logic [31:0] value,
                                      input logic [2:0] idx, input bit has,
                                      input logic [2:0] b, input logic [7:0] dx,
                                      input logic [7:0] dy);
    dir_row_t row;
    row.item.op = op;
    row.item.value = value;
    row.item.button_index = idx;
    row.has_want = has;
    row.want.buttons = b;
    row.want.delta_x = dx;
    row.want.delta_y = dy;
    return row;
  endfunction

  // Motion amounts: extremes, raw random, mostly small
  function automatic logic [31:0] rand_amount();
    case ($urandom_range(0, 15))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'($urandom_range(0, 400)) - 32'd200;
    endcase
  endfunction

  // Position under 151 report units from the last latched one, or a raw amount
  function automatic logic [31:0] rand_position(input longint base, input logic [23:0] div);
    longint d;
    longint p;
    if ($urandom_range(0, 4) == 0) begin
      return rand_amount();
    end
    d = (div == 0) ? 64'sd1 : longint'(div);
    p = base + (longint'($urandom_range(0, 300)) - 150) * d
        + longint'($urandom_range(0, int'(d - 1)));
    return p[31:0];
  endfunction

  function automatic ev_item_t rand_event();
    ev_item_t e;
    e.value = $urandom;
    e.button_index = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0, 1: begin
        e.op = OP_REL_X;
        e.value = rand_amount();
      end
      2, 3: begin
        e.op = OP_REL_Y;
        e.value = rand_amount();
      end
      4, 5: begin
        if (abs_on) begin
          e.op = OP_ABS_X;
          e.value = rand_position(last_x, div_x);
        end else begin
          e.op = OP_REL_X;
          e.value = rand_amount();
        end
      end
      6, 7: begin
        if (abs_on) begin
          e.op = OP_ABS_Y;
          e.value = rand_position(last_y, div_y);
        end else begin
          e.op = OP_REL_Y;
          e.value = rand_amount();
        end
      end
      default: begin
        e.op = OP_BUTTON;
        e.button_index = 3'($urandom_range(0, 4));
        if ($urandom_range(0, 1) == 0) begin
          e.value = '0;
        end
      end
    endcase
    return e;
  endfunction

  task automatic gap(input int n);
    repeat (n) begin
      @(negedge clk);
      ev_valid <= 1'b0;
    end
  endtask

  // Offer one event beat; record the expected report once it is taken
  task automatic offer(input ev_item_t e, input bit typed, input rpt_item_t want);
    bit        fired;
    rpt_item_t r;
    if (!no_idle) begin
      if (quiet_items > 0) begin
        quiet_items--;
      end else if ($urandom_range(0, 49) == 0) begin
        quiet_items = $urandom_range(20, 80);
      end else if ($urandom_range(0, 4) == 0) begin
        gap($urandom_range(1, 15));
      end
    end
    @(negedge clk);
    ev_valid <= 1'b1;
    ev <= e;
    do @(posedge clk); while (ev_stall);
    apply_pointer_event(e, fired, r);
    if (typed) begin
      pending_reports.push_back(want);
    end else if (fired) begin
      pending_reports.push_back(r);
    end
  endtask

  // Drop valid and wait for every outstanding report, then some slack
  task automatic settle(input int extra);
    @(negedge clk);
    ev_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ABS_MODE: abs_on = data[0];
      REG_SCALE_X: div_x = data[23:0];
      REG_SCALE_Y: div_y = data[23:0];
      REG_START_X: begin
        cur_x = longint'($signed(data));
        last_x = cur_x;
      end
      REG_START_Y: begin
        cur_y = longint'($signed(data));
        last_y = cur_y;
      end
      default: ;
    endcase
  endtask

  // One register setting followed by random event sequences
  task automatic run_phase(input bit abs, input logic [31:0] sx, input logic [31:0] sy,
                           input logic [31:0] stx, input logic [31:0] sty, input int n,
                           input int hold_at, input int drain_at);
    int       done;
    int       left;
    ev_item_t e;
    settle(SETTLE_CYCLES);
    reg_write(REG_ABS_MODE, {31'd0, abs});
    reg_write(REG_SCALE_X, sx);
    reg_write(REG_SCALE_Y, sy);
    reg_write(REG_START_X, stx);
    reg_write(REG_START_Y, sty);
    done = 0;
    left = 0;
    while (done < n) begin
      if (left == 0 && $urandom_range(0, 9) == 0) begin
        // noise: spare opcodes, bad button slot, back-to-back sync
        e = rand_event();
        case ($urandom_range(0, 2))
          0: e.op = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
          1: begin
            e.op = OP_BUTTON;
            e.button_index = 3'($urandom_range(5, 7));
          end
          default: e.op = OP_SYNC;
        endcase
        offer(e, 1'b0, '0);
      end else begin
        if (left == 0) begin
          left = $urandom_range(1, 7);
        end
        e = rand_event();
        // most sequences close with a sync, a few are left open
        if (left == 1 && $urandom_range(0, 6) != 0) begin
          e.op = OP_SYNC;
        end
        left--;
        offer(e, 1'b0, '0);
        done++;
        if (done == hold_at) begin
          hold_req = 1'b1;
        end
        if (done == drain_at) begin
          settle(0);
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("[boot_mouse_report_builder_core] ERROR");
    $finish;
  end

  // Report sink: random stall bursts, quiet stretches, one long hold-off
  initial begin : report_sink
    int burst;
    int calm;
    burst = 0;
    calm = 0;
    rpt_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rpt_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        rpt_stall <= 1'b0;
      end else if (burst > 0) begin
        rpt_stall <= 1'b1;
        burst--;
      end else if (no_idle || calm > 0) begin
        rpt_stall <= 1'b0;
        if (calm > 0) calm--;
      end else if ($urandom_range(0, 99) == 0) begin
        calm = $urandom_range(30, 150);
        rpt_stall <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        rpt_stall <= 1'b1;
        burst = $urandom_range(0, 14);
      end else begin
        rpt_stall <= 1'b0;
      end
    end
  end

  // Compare each report beat with the oldest expectation
  always @(posedge clk) begin : report_check
    rpt_item_t want;
    if (!rst && rpt_valid && !rpt_stall) begin
      if (pending_reports.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("unexpected report: buttons=%b dx=%0d dy=%0d",
                   rpt.buttons, rpt.delta_x, rpt.delta_y);
        end
      end else begin
        want = pending_reports.pop_front();
        if (rpt.buttons !== want.buttons || rpt.delta_x !== want.delta_x ||
            rpt.delta_y !== want.delta_y) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("report mismatch: expected buttons=%b dx=%0d dy=%0d, ",
                     want.buttons, want.delta_x, want.delta_y,
                     "got buttons=%b dx=%0d dy=%0d",
                     rpt.buttons, rpt.delta_x, rpt.delta_y);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    ev_valid = 1'b0;
    ev = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_cnt = 0;
    hold_req = 1'b0;
    no_idle = 1'b0;
    quiet_items = 0;

    // state after reset
    abs_on = 1'b0;
    div_x = 24'd1;
    div_y = 24'd1;
    btn_state = '0;
    acc_x = 0;
    acc_y = 0;
    dirty = 1'b0;
    cur_x = 0;
    cur_y = 0;
    last_x = 0;
    last_y = 0;
    latched = 1'b0;
    rem_x = 0;
    rem_y = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // Directed events in relative mode at reset settings
    dir_rows.push_back(mk_row(OP_SYNC, 32'd0, SLOT_LEFT, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_REL_X, 32'h7FFF_FFFF, SLOT_LEFT, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_REL_X, 32'h7FFF_FFFF, SLOT_LEFT, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_REL_Y, 32'h8000_0000, SLOT_LEFT, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_REL_Y, 32'hFFFF_FFFF, SLOT_LEFT, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_SYNC, 32'd0, SLOT_LEFT, 1'b1, 3'b000, 8'h7F, 8'h81));
    dir_rows.push_back(mk_row(OP_BUTTON, 32'd1, SLOT_LEFT, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_BUTTON, 32'h8000_0000, SLOT_RIGHT, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_BUTTON, 32'hFFFF_FFFF, SLOT_MIDDLE, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_BUTTON, 32'd1, SLOT_SIDE, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_BUTTON, 32'd1, SLOT_EXTRA, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_SYNC, 32'hFFFF_FFFF, 3'd7, 1'b1, 3'b111, 8'h00, 8'h00));
    // ignored: bad button slots, absolute events in relative mode, spare opcodes
    dir_rows.push_back(mk_row(OP_BUTTON, 32'd1, 3'd5, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_BUTTON, 32'd0, 3'd7, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_ABS_X, 32'd100, SLOT_LEFT, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_ABS_Y, 32'hFFFF_FFFB, SLOT_LEFT, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_SPARE_6, 32'h7FFF_FFFF, SLOT_LEFT, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_SPARE_7, 32'h8000_0000, 3'd7, 1'b0, 3'b000, 8'h00, 8'h00));
    // nothing pending, so no report
    dir_rows.push_back(mk_row(OP_SYNC, 32'd0, SLOT_LEFT, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_BUTTON, 32'd0, SLOT_LEFT, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_REL_X, 32'd127, SLOT_LEFT, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_REL_Y, 32'hFFFF_FF80, SLOT_LEFT, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_SYNC, 32'd0, SLOT_LEFT, 1'b1, 3'b110, 8'h7F, 8'h81));
    dir_rows.push_back(mk_row(OP_REL_X, 32'hFFFF_FF81, SLOT_LEFT, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_REL_Y, 32'd5, SLOT_LEFT, 1'b0, 3'b000, 8'h00, 8'h00));
    dir_rows.push_back(mk_row(OP_SYNC, 32'd0, SLOT_LEFT, 1'b1, 3'b110, 8'h81, 8'h05));
    foreach (dir_rows[i]) begin
      offer(dir_rows[i].item, dir_rows[i].has_want, dir_rows[i].want);
    end

    // Random phases over a spread of register settings
    run_phase(1'b0, 32'd1, 32'd1, 32'd0, 32'd0, 250, 60, -1);
    run_phase(1'b1, 32'd1, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 200, -1, 100);
    run_phase(1'b1, 32'h00FF_FFFF, 32'd3, 32'd0, 32'd0, 200, -1, -1);
    run_phase(1'b1, 32'($urandom_range(1, 24'hFF_FFFF)), 32'($urandom_range(1, 1000)),
              $urandom, $urandom, 200, -1, -1);
    run_phase(1'b1, 32'd0, 32'd7, 32'hFFFF_FFFF, 32'd1, 150, -1, -1);
    run_phase(1'b0, 32'd5, 32'd9, 32'hFFFF_FF9C, 32'd100, 200, -1, -1);
    no_idle = 1'b1;
    run_phase(1'b1, 32'($urandom_range(1, 64)), 32'($urandom_range(1, 64)),
              $urandom, $urandom, 250, -1, -1);

    settle(SETTLE_CYCLES);
    if (fail_cnt == 0) begin
      $display("[boot_mouse_report_builder_core] OK");
    end else begin
      $display("[boot_mouse_report_builder_core] ERROR");
    end
    $finish;
  end

endmodule
